FILE: hdl/alu_pkg.sv
// Shared types and constants for the 8-bit CPU ALU with flags.
// Used by alu_core, the top level cpu_alu_with_flags and alu_checker.
// No dependencies.
`default_nettype none

package alu_pkg;

  // Field widths of one operation beat and of one result beat.
  localparam int unsigned OP_W        = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WIDE_W      = 16;
  localparam int unsigned FLAG_W      = 4;
  localparam int unsigned IN_DATA_W   = 40;  // 8 + 16 + 16, already whole bytes
  localparam int unsigned IN_USER_W   = 4;
  localparam int unsigned OUT_DATA_W  = 40;  // 8 + 16 + 4 + 8 = 36, padded to 40

  // Bit positions inside the flag nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 4'd0,
    OP_INC   = 4'd1,
    OP_DEC   = 4'd2,
    OP_ADD8  = 4'd3,
    OP_ADD16 = 4'd4,
    OP_AND   = 4'd5,
    OP_XOR   = 4'd6,
    OP_OR    = 4'd7,
    OP_SUB   = 4'd8,
    OP_SBC   = 4'd9,
    OP_CP    = 4'd10,
    OP_RRCA  = 4'd11,
    OP_RLCA  = 4'd12,
    OP_CPL   = 4'd13
  } op_e;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_result;
    logic [WIDE_W-1:0] wide_result;
    logic [FLAG_W-1:0] flag_bits;
    logic [BYTE_W-1:0] acc_value;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: hdl/cpu_alu_with_flags.sv
// Top level of the 8-bit CPU ALU with accumulator and flags.
// Depends on alu_pkg and alu_core.
`default_nettype none

// An 8-bit CPU ALU in the style of the SM83 core, holding an accumulator and
// the Z, N, H and C flags. Each input beat carries one operation (on tuser)
// and its operands (on tdata); each produces exactly one result beat with the
// byte result, the 16-bit sum of a wide add, the new flags and the new
// accumulator. The block takes one operation per clock cycle while the output
// is not stalled; each moves from the input register to the result register.
// Throughput is set by the accumulator and flag registers: they are updated
// at the same edge at which an operation moves from the input register into
// the result register, so the next operation already sees them. The result
// register and the input register together let a new beat enter while a
// finished result still waits for the consumer. Accumulator and flags reset
// to zero. Operation codes 14 and 15 change nothing and report the current
// state.

module cpu_alu_with_flags (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0 up: operand[7:0], wide_dest[23:8], wide_operand[39:24].
  input  logic [alu_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: op[3:0].
  input  logic [alu_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0 up: byte_result[7:0], wide_result[23:8],
  // flag_bits[27:24], acc_value[35:28], zero fill[39:36].
  output logic [alu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import alu_pkg::*;

  // Input register: holds one accepted operation until it is executed.
  logic              in_valid_q;
  logic [OP_W-1:0]   in_op_q;
  logic [BYTE_W-1:0] in_operand_q;
  logic [WIDE_W-1:0] in_wdest_q;
  logic [WIDE_W-1:0] in_wop_q;

  // Architectural state.
  logic [BYTE_W-1:0] acc_q;
  logic [FLAG_W-1:0] flags_q;

  // Result register.
  logic              out_valid_q;
  alu_res_t          out_res_q;

  alu_res_t          res;
  logic              advance;
  logic              in_take;

  // The operation in the input register executes once the result register
  // is free or being emptied this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  alu_core u_core (
    .op_i           (in_op_q),
    .operand_i      (in_operand_q),
    .wide_dest_i    (in_wdest_q),
    .wide_operand_i (in_wop_q),
    .acc_i          (acc_q),
    .flags_i        (flags_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        acc_q       <= res.acc_value;
        flags_q     <= res.flag_bits;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q      <= s_axis_tuser_i;
      in_operand_q <= s_axis_tdata_i[7:0];
      in_wdest_q   <= s_axis_tdata_i[23:8];
      in_wop_q     <= s_axis_tdata_i[39:24];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_res_q.acc_value, out_res_q.flag_bits,
                            out_res_q.wide_result, out_res_q.byte_result};

endmodule

`default_nettype wire

FILE: hdl/alu_core.sv
// Combinational datapath of the ALU: one operation against the current
// accumulator and flags. Depends on alu_pkg.
`default_nettype none

module alu_core (
  input  logic [alu_pkg::OP_W-1:0]   op_i,
  input  logic [alu_pkg::BYTE_W-1:0] operand_i,
  input  logic [alu_pkg::WIDE_W-1:0] wide_dest_i,
  input  logic [alu_pkg::WIDE_W-1:0] wide_operand_i,
  input  logic [alu_pkg::BYTE_W-1:0] acc_i,
  input  logic [alu_pkg::FLAG_W-1:0] flags_i,
  output alu_pkg::alu_res_t          res_o
);
  import alu_pkg::*;

  op_e               op;
  logic              borrow;
  logic [BYTE_W:0]   add_sum;
  logic [4:0]        add_nib;
  logic [BYTE_W:0]   sub_diff;
  logic [4:0]        sub_nib;
  logic [WIDE_W:0]   wide_sum;
  logic [12:0]       wide_low;
  logic [BYTE_W-1:0] inc_val;
  logic [BYTE_W-1:0] dec_val;
  logic [BYTE_W-1:0] logic_val;

  assign op = op_e'(op_i);

  // Borrow-in is the stored carry only for subtract with borrow.
  assign borrow   = (op == OP_SBC) ? flags_i[FLAG_C] : 1'b0;

  assign add_sum  = {1'b0, acc_i} + {1'b0, operand_i};
  assign add_nib  = {1'b0, acc_i[3:0]} + {1'b0, operand_i[3:0]};
  // A negative difference shows up as the top bit of the widened result.
  assign sub_diff = {1'b0, acc_i} - {1'b0, operand_i} - {{BYTE_W{1'b0}}, borrow};
  assign sub_nib  = {1'b0, acc_i[3:0]} - {1'b0, operand_i[3:0]} - {4'd0, borrow};
  assign wide_sum = {1'b0, wide_dest_i} + {1'b0, wide_operand_i};
  assign wide_low = {1'b0, wide_dest_i[11:0]} + {1'b0, wide_operand_i[11:0]};
  assign inc_val  = operand_i + 8'd1;
  assign dec_val  = operand_i - 8'd1;

  always_comb begin
    case (op)
      OP_AND:  logic_val = acc_i & operand_i;
      OP_XOR:  logic_val = acc_i ^ operand_i;
      default: logic_val = acc_i | operand_i;
    endcase
  end

  always_comb begin
    res_o.acc_value   = acc_i;
    res_o.flag_bits   = flags_i;
    res_o.wide_result = '0;
    case (op)
      OP_LOAD: begin
        res_o.acc_value = operand_i;
      end
      OP_INC: begin
        res_o.flag_bits = {inc_val == '0, 1'b0, operand_i[3:0] == 4'hf, flags_i[FLAG_C]};
      end
      OP_DEC: begin
        res_o.flag_bits = {dec_val == '0, 1'b1, operand_i[3:0] == 4'h0, flags_i[FLAG_C]};
      end
      OP_ADD8: begin
        res_o.acc_value = add_sum[BYTE_W-1:0];
        res_o.flag_bits = {add_sum[BYTE_W-1:0] == '0, 1'b0, add_nib[4], add_sum[BYTE_W]};
      end
      OP_ADD16: begin
        res_o.wide_result = wide_sum[WIDE_W-1:0];
        res_o.flag_bits   = {flags_i[FLAG_Z], 1'b0, wide_low[12], wide_sum[WIDE_W]};
      end
      OP_AND: begin
        res_o.acc_value = logic_val;
        res_o.flag_bits = {logic_val == '0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR, OP_OR: begin
        res_o.acc_value = logic_val;
        res_o.flag_bits = {logic_val == '0, 1'b0, 1'b0, 1'b0};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (op != OP_CP) begin
          res_o.acc_value = sub_diff[BYTE_W-1:0];
        end
        res_o.flag_bits = {sub_diff[BYTE_W-1:0] == '0, 1'b1, sub_nib[4], sub_diff[BYTE_W]};
      end
      OP_RRCA: begin
        res_o.acc_value = {acc_i[0], acc_i[BYTE_W-1:1]};
        res_o.flag_bits = {3'b000, acc_i[0]};
      end
      OP_RLCA: begin
        res_o.acc_value = {acc_i[BYTE_W-2:0], acc_i[BYTE_W-1]};
        res_o.flag_bits = {3'b000, acc_i[BYTE_W-1]};
      end
      OP_CPL: begin
        res_o.acc_value = ~acc_i;
        res_o.flag_bits = {flags_i[FLAG_Z], 1'b1, 1'b1, flags_i[FLAG_C]};
      end
      default: begin
        // Unused codes leave accumulator and flags as they are.
      end
    endcase
    // Increment and decrement report their own result; all others the accumulator.
    case (op)
      OP_INC:  res_o.byte_result = inc_val;
      OP_DEC:  res_o.byte_result = dec_val;
      default: res_o.byte_result = res_o.acc_value;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/alu_checker.sv
// Port-level checks for cpu_alu_with_flags and the bind that attaches them.
// Depends on alu_pkg and the top level cpu_alu_with_flags.
`default_nettype none

module alu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [alu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import alu_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // With no result pending the input register can always drain.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while result register empty");

  // After a beat is accepted and held in the input register, a result beat is
  // on offer: either its own result or an older one still stalled at the output.
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> ##1 m_axis_tvalid_o)
    else $error("accepted beat did not produce a result in time");

  // A nonzero wide sum only comes from the wide add, which clears N.
  a_wide_clears_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[23:8] != 16'd0) |-> !m_axis_tdata_o[24 + FLAG_N])
    else $error("wide result with N flag set");

endmodule

bind cpu_alu_with_flags alu_checker u_alu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
